// File: rtl/tsme_pkg.sv
package tsme_pkg;

  localparam int VAL_W = 32;
  localparam int OP_W  = 3;

  localparam logic [OP_W-1:0] OP_APPEND_A = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND_B = 3'd1;
  localparam logic [OP_W-1:0] OP_BOTH     = 3'd2;
  localparam logic [OP_W-1:0] OP_ONLY_A   = 3'd3;
  localparam logic [OP_W-1:0] OP_ONLY_B   = 3'd4;
  localparam logic [OP_W-1:0] OP_UNION    = 3'd5;

  // token walking down the compare chain
  typedef struct packed {
    logic             vld;
    logic             fin;
    logic             src_b;
    logic             want;
    logic             hit;
    logic [VAL_W-1:0] val;
  } tsme_tok_t;

  // append write broadcast to every cell
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic [VAL_W-1:0] wdata;
  } tsme_wr_t;

endpackage

// File: rtl/tsme_cell.sv
module tsme_cell import tsme_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  tsme_wr_t         wr,
  input  logic [CW-1:0]    cnt_a,
  input  logic [CW-1:0]    cnt_b,
  input  tsme_tok_t        tok_i,
  output tsme_tok_t        tok_o,
  output logic [VAL_W-1:0] a_val,
  output logic [VAL_W-1:0] b_val
);

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [VAL_W-1:0] a_r;
  logic [VAL_W-1:0] b_r;
  tsme_tok_t        tok_r;
  tsme_tok_t        tok_nxt;
  logic             match;

  always_comb begin
    if (tok_i.src_b) begin
      match = (IDX_C < cnt_a) && (a_r == tok_i.val);
    end else begin
      match = (IDX_C < cnt_b) && (b_r == tok_i.val);
    end
    tok_nxt     = tok_i;
    tok_nxt.hit = tok_i.hit | (tok_i.vld & match);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_a && (cnt_a == IDX_C)) begin
      a_r <= wr.wdata;
    end
    if (wr.wr_b && (cnt_b == IDX_C)) begin
      b_r <= wr.wdata;
    end
  end

  assign tok_o = tok_r;
  assign a_val = a_r;
  assign b_val = b_r;

endmodule

// File: rtl/two_set_membership_engine.sv
// Two-list set engine: lists A and B of up to DEPTH signed 32-bit values each.
// Input channel (in_valid/in_ready): in_opcode, in_value. Opcodes 0/1 append
// in_value to A/B; 2..5 stream A-in-B, A-not-in-B, B-not-in-A, or the union.
// Result channel (out_valid/out_ready): out_element, out_valid_res, out_last,
// out_status. Every input gives one or more beats; out_last marks the final.
// Appends and unused opcodes answer with one beat, in the cycle after accept;
// out_status is 1 when an append finds its list full.
// Queries feed the source list, one entry per cycle while the output is not
// stalled, into a row of DEPTH cells; each cell holds one entry of A and of B
// and compares the passing value against the other list. One item is worked
// on at a time; a new one is accepted once the previous answer has left the
// chain.
// Reset empties both lists and clears the chain and the output valid flag.
// While a beat waits and out_ready is low the whole chain holds its place, so no beat is lost.
module two_set_membership_engine import tsme_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_element,
  output logic                    out_valid_res,
  output logic                    out_last,
  output logic                    out_status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  localparam logic [1:0] P_A_OUT = 2'd0;
  localparam logic [1:0] P_A_IN  = 2'd1;
  localparam logic [1:0] P_B_OUT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FEED  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [1:0]        pass_r, pass_nxt;
  logic [1:0]        pass_end_r, pass_end_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     cnt_a_r, cnt_a_nxt;
  logic [CW-1:0]     cnt_b_r, cnt_b_nxt;
  logic              pend_vld_r, pend_vld_nxt;
  logic [VAL_W-1:0]  pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_element_r, out_element_nxt;
  logic              out_valid_res_r, out_valid_res_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_status_r, out_status_nxt;

  logic              adv;
  logic              src_b;
  logic [CW-1:0]     src_cnt;
  logic [VAL_W-1:0]  src_val;
  tsme_wr_t          wr;
  tsme_tok_t         tok_head;
  tsme_tok_t         tok_w [DEPTH+1];
  tsme_tok_t         tail;
  logic [VAL_W-1:0]  a_vals [DEPTH];
  logic [VAL_W-1:0]  b_vals [DEPTH];

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      tsme_cell #(.IDX(g), .CW(CW)) u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .wr    (wr),
        .cnt_a (cnt_a_r),
        .cnt_b (cnt_b_r),
        .tok_i (tok_w[g]),
        .tok_o (tok_w[g+1]),
        .a_val (a_vals[g]),
        .b_val (b_vals[g])
      );
    end
  endgenerate

  assign tok_w[0] = tok_head;
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && adv;
  assign tail     = tok_w[DEPTH];
  assign src_b    = (pass_r == P_B_OUT);
  assign src_cnt  = src_b ? cnt_b_r : cnt_a_r;
  assign src_val  = src_b ? b_vals[idx_r[IW-1:0]] : a_vals[idx_r[IW-1:0]];

  always_comb begin
    state_nxt         = state_r;
    pass_nxt          = pass_r;
    pass_end_nxt      = pass_end_r;
    idx_nxt           = idx_r;
    cnt_a_nxt         = cnt_a_r;
    cnt_b_nxt         = cnt_b_r;
    pend_vld_nxt      = pend_vld_r;
    pend_nxt          = pend_r;
    out_valid_nxt     = out_valid_r && !out_ready;
    out_element_nxt   = out_element_r;
    out_valid_res_nxt = out_valid_res_r;
    out_last_nxt      = out_last_r;
    out_status_nxt    = out_status_r;
    wr                = '0;
    wr.wdata          = in_value;
    tok_head          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          out_element_nxt   = '0;
          out_valid_res_nxt = 1'b0;
          out_last_nxt      = 1'b1;
          out_status_nxt    = 1'b0;
          idx_nxt           = '0;
          unique case (in_opcode)
            OP_APPEND_A: begin
              out_valid_nxt = 1'b1;
              if (cnt_a_r == FULL) begin
                out_status_nxt = 1'b1;
              end else begin
                wr.wr_a   = 1'b1;
                cnt_a_nxt = cnt_a_r + 1'b1;
              end
            end
            OP_APPEND_B: begin
              out_valid_nxt = 1'b1;
              if (cnt_b_r == FULL) begin
                out_status_nxt = 1'b1;
              end else begin
                wr.wr_b   = 1'b1;
                cnt_b_nxt = cnt_b_r + 1'b1;
              end
            end
            OP_BOTH: begin
              pass_nxt     = P_A_IN;
              pass_end_nxt = P_A_IN;
              state_nxt    = S_FEED;
            end
            OP_ONLY_A: begin
              pass_nxt     = P_A_OUT;
              pass_end_nxt = P_A_OUT;
              state_nxt    = S_FEED;
            end
            OP_ONLY_B: begin
              pass_nxt     = P_B_OUT;
              pass_end_nxt = P_B_OUT;
              state_nxt    = S_FEED;
            end
            OP_UNION: begin
              pass_nxt     = P_A_OUT;
              pass_end_nxt = P_B_OUT;
              state_nxt    = S_FEED;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_FEED: begin
        if (adv) begin
          if (idx_r < src_cnt) begin
            tok_head.vld   = 1'b1;
            tok_head.src_b = src_b;
            tok_head.want  = (pass_r == P_A_IN);
            tok_head.val   = src_val;
            idx_nxt        = idx_r + 1'b1;
          end else if (pass_r != pass_end_r) begin
            pass_nxt = pass_r + 2'd1;
            idx_nxt  = '0;
          end else begin
            tok_head.fin = 1'b1;
            state_nxt    = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (adv && tail.fin) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // hold one answer back so the final beat can carry last
    if (adv && tail.vld && (tail.hit == tail.want)) begin
      if (pend_vld_r) begin
        out_valid_nxt     = 1'b1;
        out_element_nxt   = pend_r;
        out_valid_res_nxt = 1'b1;
        out_last_nxt      = 1'b0;
        out_status_nxt    = 1'b0;
      end
      pend_nxt     = tail.val;
      pend_vld_nxt = 1'b1;
    end else if (adv && tail.fin) begin
      out_valid_nxt     = 1'b1;
      out_element_nxt   = pend_vld_r ? pend_r : '0;
      out_valid_res_nxt = pend_vld_r;
      out_last_nxt      = 1'b1;
      out_status_nxt    = 1'b0;
      pend_vld_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= P_A_OUT;
      pass_end_r  <= P_A_OUT;
      idx_r       <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      pass_end_r  <= pass_end_nxt;
      idx_r       <= idx_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r          <= pend_nxt;
    out_element_r   <= out_element_nxt;
    out_valid_res_r <= out_valid_res_nxt;
    out_last_r      <= out_last_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_element   = $signed(out_element_r);
  assign out_valid_res = out_valid_res_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_vld_r)
    else $error("held answer left over while idle");

  a_idle_chain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!tail.vld && !tail.fin))
    else $error("token leaving chain while idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= FULL) && (cnt_b_r <= FULL))
    else $error("list count beyond depth");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_opcode == OP_APPEND_A) && (cnt_a_r == FULL))
      |=> (cnt_a_r == FULL) && out_status_r)
    else $error("append to full list not refused");
`endif

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tsme_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_REQUESTS = 300;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [VAL_W-1:0] element;
    logic                    valid_res;
    logic                    last;
    logic                    status;
  } answer_beat_t;

  class set_scoreboard;
    logic [VAL_W-1:0] list_a[$];
    logic [VAL_W-1:0] list_b[$];
    answer_beat_t     expected[$];
    int               errors = 0;

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_beat(logic [VAL_W-1:0] elem, logic vres, logic last, logic status);
      answer_beat_t b;
      b.element   = elem;
      b.valid_res = vres;
      b.last      = last;
      b.status    = status;
      expected.push_back(b);
    endfunction

    function bit holds(logic [VAL_W-1:0] lst[$], logic [VAL_W-1:0] v);
      foreach (lst[i]) begin
        if (lst[i] == v) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int emit_matching(logic [VAL_W-1:0] src[$], logic [VAL_W-1:0] other[$],
                               bit want_in);
      int n = 0;
      foreach (src[i]) begin
        if (holds(other, src[i]) == want_in) begin
          push_beat(src[i], 1'b1, 1'b0, 1'b0);
          n++;
        end
      end
      return n;
    endfunction

    // beats this request should produce, in order
    function void take_request(logic [OP_W-1:0] op, logic [VAL_W-1:0] v);
      int n = 0;
      case (op)
        OP_APPEND_A: begin
          push_beat('0, 1'b0, 1'b1, list_a.size() >= LIST_DEPTH);
          if (list_a.size() < LIST_DEPTH) list_a.push_back(v);
          return;
        end
        OP_APPEND_B: begin
          push_beat('0, 1'b0, 1'b1, list_b.size() >= LIST_DEPTH);
          if (list_b.size() < LIST_DEPTH) list_b.push_back(v);
          return;
        end
        OP_BOTH:   n = emit_matching(list_a, list_b, 1'b1);
        OP_ONLY_A: n = emit_matching(list_a, list_b, 1'b0);
        OP_ONLY_B: n = emit_matching(list_b, list_a, 1'b0);
        OP_UNION: begin
          n = emit_matching(list_a, list_b, 1'b0);
          n += emit_matching(list_a, list_b, 1'b1);
          n += emit_matching(list_b, list_a, 1'b0);
        end
        default: n = 0;
      endcase
      if (n == 0) push_beat('0, 1'b0, 1'b1, 1'b0);
      else expected[expected.size()-1].last = 1'b1;
    endfunction

    task check_beat(logic [VAL_W-1:0] elem, logic vres, logic last, logic status);
      answer_beat_t want;
      if (expected.size() == 0) begin
        report($sformatf("unexpected beat element=%0d valid_res=%0b last=%0b status=%0b",
                         $signed(elem), vres, last, status));
        return;
      end
      want = expected.pop_front();
      if (elem !== want.element)
        report($sformatf("element got %0d want %0d", $signed(elem), want.element));
      if (vres !== want.valid_res)
        report($sformatf("valid_res got %0b want %0b", vres, want.valid_res));
      if (last !== want.last)
        report($sformatf("last got %0b want %0b", last, want.last));
      if (status !== want.status)
        report($sformatf("status got %0b want %0b", status, want.status));
    endtask

    function int outstanding();
      return expected.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  logic [OP_W-1:0]         in_opcode;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [VAL_W-1:0] out_element;
  logic                    out_valid_res;
  logic                    out_last;
  logic                    out_status;

  set_scoreboard board = new();
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit hold_req = 1'b0;
  int cycle_count = 0;

  two_set_membership_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_opcode    (in_opcode),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_element  (out_element),
    .out_valid_res(out_valid_res),
    .out_last     (out_last),
    .out_status   (out_status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("two_set_membership_engine verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) board.take_request(in_opcode, in_value);
    if (rst_n && out_valid && out_ready)
      board.check_beat(out_element, out_valid_res, out_last, out_status);
  end

  // result side: random back-pressure plus one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= rst_n && !(rx_idle && $urandom_range(0, 99) < 37);
      end
    end
  end

  task automatic send_request(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] val);
    while (tx_idle && $urandom_range(0, 99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    logic [VAL_W-1:0] pool[8];
    logic [VAL_W-1:0] v;
    logic [OP_W-1:0]  op;
    int               r;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_opcode = OP_APPEND_A;
    in_value  = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty lists, spare opcodes
    send_request(OP_BOTH, 32'h0);
    send_request(OP_ONLY_A, 32'hFFFF_FFFF);
    send_request(OP_ONLY_B, 32'h0);
    send_request(OP_UNION, 32'hFFFF_FFFF);
    send_request(OP_SPARE_LO, 32'h1234_5678);
    send_request(OP_SPARE_HI, 32'hFFFF_FFFF);
    // A only, B empty
    send_request(OP_APPEND_A, 32'h8000_0000);
    send_request(OP_APPEND_A, 32'h7FFF_FFFF);
    send_request(OP_APPEND_A, 32'h0);
    send_request(OP_APPEND_A, 32'hFFFF_FFFF);
    send_request(OP_BOTH, 32'h0);
    send_request(OP_ONLY_B, 32'h0);
    send_request(OP_UNION, 32'h0);
    // overlap and duplicates
    send_request(OP_APPEND_B, 32'hFFFF_FFFF);
    send_request(OP_APPEND_B, 32'h7FFF_FFFF);
    send_request(OP_APPEND_B, 32'h5);
    send_request(OP_APPEND_A, 32'hFFFF_FFFF);
    send_request(OP_BOTH, 32'h0);
    send_request(OP_ONLY_A, 32'h0);
    send_request(OP_ONLY_B, 32'h0);
    send_request(OP_UNION, 32'h0);

    pool[0] = 32'h8000_0000;
    pool[1] = 32'h7FFF_FFFF;
    pool[2] = 32'h0;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) pool[i] = $urandom();

    for (int k = 0; k < RANDOM_REQUESTS; k++) begin
      if (k == 60) hold_req = 1'b1;
      tx_idle = !(k >= 200 && k < 260);
      rx_idle = tx_idle;
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_APPEND_A;
      else if (r < 60) op = OP_APPEND_B;
      else if (r < 70) op = OP_BOTH;
      else if (r < 78) op = OP_ONLY_A;
      else if (r < 86) op = OP_ONLY_B;
      else if (r < 95) op = OP_UNION;
      else op = r[0] ? OP_SPARE_HI : OP_SPARE_LO;
      v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 7)] : $urandom();
      send_request(op, v);
    end
    in_valid <= 1'b0;
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (4 * LIST_DEPTH) @(posedge clk);
    if (board.errors == 0) begin
      $display("two_set_membership_engine verification clean");
    end else begin
      $display("two_set_membership_engine verification failed");
    end
    $finish;
  end

endmodule
